>>> rtl/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

  // Character width taken from the input stream
  localparam int CHAR_BITS = 16;

  localparam int ACC_W  = 64;
  localparam int BASE_W = 5;
  localparam int PROD_W = ACC_W + BASE_W;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_BASE_SELECT = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  // Parse phases
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_ZERO   = 3'd1;
  localparam logic [2:0] PH_NEED   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_TRAIL  = 3'd4;

  localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(8'h20);
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = CHAR_BITS'(8'h2B);
  localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(8'h2D);
  localparam logic [CHAR_BITS-1:0] CH_0     = CHAR_BITS'(8'h30);
  localparam logic [CHAR_BITS-1:0] CH_9     = CHAR_BITS'(8'h39);
  localparam logic [CHAR_BITS-1:0] CH_LC_A  = CHAR_BITS'(8'h61);
  localparam logic [CHAR_BITS-1:0] CH_LC_F  = CHAR_BITS'(8'h66);
  localparam logic [CHAR_BITS-1:0] CH_UC_A  = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_UC_F  = CHAR_BITS'(8'h46);
  localparam logic [CHAR_BITS-1:0] CH_LC_X  = CHAR_BITS'(8'h78);
  localparam logic [CHAR_BITS-1:0] CH_UC_X  = CHAR_BITS'(8'h58);

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

  localparam logic [ACC_W-1:0] SIGNED_MIN_MAG = {1'b1, {(ACC_W-1){1'b0}}};

  // One finished result: ok flag, sign and magnitude
  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [ACC_W-1:0] mag;
  } result_t;

endpackage

>>> rtl/ascii_integer_parser.sv
`timescale 1ns / 1ps

// ascii_integer_parser
//
// Parses a number string, one character per input transaction, into a 64-bit
// integer (signed or unsigned, base 1..31 or auto with 0x prefix).
// Input stream: s_tdata carries the character code, s_tuser says whether the
// character is present, s_tlast closes the string. Only the transaction with
// s_tlast gives a result: m_tuser is the ok flag, m_tdata the value (0 when
// ok is low). The APB port holds base_select (0x0) and signed_mode (0x4);
// write them only while no string is in flight.
// Throughput: one character per cycle while s_tready is high, set by the single
// multiply-add and overflow check between the parse state registers. The result
// is registered into the output register, or into the skid register if it is full.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; the parser keeps taking characters until the skid
// register is full, then drops s_tready until the output moves.
// Reset (rst, synchronous): parse state cleared, outputs empty,
// base_select = 0 (auto), signed_mode = 1.

module ascii_integer_parser (
  input  logic                    clk,
  input  logic                    rst,
  // APB configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [aip_pkg::ADDR_W-1:0] paddr,
  input  logic [aip_pkg::DATA_W-1:0] pwdata,
  output logic [aip_pkg::DATA_W-1:0] prdata,
  output logic                    pready,
  // Character stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,   // [15:0] char_code
  input  logic                    s_tuser,   // [0] char_present
  input  logic                    s_tlast,
  // Result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [63:0]             m_tdata,   // [63:0] value_bits
  output logic                    m_tuser    // [0] ok
);
  import aip_pkg::*;

  // Configuration registers
  logic [BASE_W-1:0] base_select;
  logic              signed_mode;

  // Parse state
  logic [2:0]        phase;
  logic [ACC_W-1:0]  accumulator;
  logic              negative;
  logic [BASE_W-1:0] active_base;
  logic              min_reached;
  logic              failed;

  logic [2:0]        phase_next;
  logic [ACC_W-1:0]  accumulator_next;
  logic              negative_next;
  logic [BASE_W-1:0] active_base_next;
  logic              min_reached_next;
  logic              failed_next;

  // Output register and skid register
  result_t           out_res;
  result_t           skid_res;
  logic              skid_valid;
  result_t           res_new;

  logic              in_take;
  logic              res_in;
  logic              out_free;

  // Datapath signals
  logic [CHAR_BITS-1:0] ch;
  logic                 is_space;
  logic [BASE_W-1:0]    cur_base;
  logic [BASE_W-1:0]    eff_base;
  logic                 is_dec;
  logic                 is_hex_lc;
  logic                 is_hex_uc;
  logic                 is_digit;
  logic [3:0]           digit_val;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W:0]       sum;
  logic                 dig_fail;
  logic                 dig_min;
  logic                 res_ok;

  // ------------------------------------------------------------------
  // APB: writes land on the access cycle, reads are plain muxes
  // ------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= BASE_AUTO;
      signed_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_BASE_SELECT: base_select <= pwdata[BASE_W-1:0];
        REG_SIGNED_MODE: signed_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE_SELECT: prdata = DATA_W'(base_select);
      REG_SIGNED_MODE: prdata = DATA_W'(signed_mode);
      default:         prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Character decode and multiply-add
  // ------------------------------------------------------------------
  assign ch       = s_tdata[CHAR_BITS-1:0];
  assign is_space = (ch == CH_SPACE);

  // The base is latched at the first non-space character, so a digit in the
  // leading phase already uses base_select.
  assign cur_base = (phase == PH_LEAD) ? base_select : active_base;
  assign eff_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;

  assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
  assign is_hex_lc = (eff_base == BASE_HEX) && (ch >= CH_LC_A) && (ch <= CH_LC_F);
  assign is_hex_uc = (eff_base == BASE_HEX) && (ch >= CH_UC_A) && (ch <= CH_UC_F);
  assign is_digit  = is_dec || is_hex_lc || is_hex_uc;
  // '0' has low nibble 0; 'a' and 'A' have low nibble 1
  assign digit_val = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);

  // The full product shows the overflow directly: acc > MAX/base exactly when
  // acc*base > MAX.
  assign prod = PROD_W'(accumulator) * PROD_W'(eff_base);
  assign sum  = {1'b0, prod[ACC_W-1:0]} + (ACC_W+1)'(digit_val);

  always_comb begin
    dig_min = 1'b0;
    if (!is_digit) begin
      dig_fail = 1'b1;
    end else if (signed_mode) begin
      dig_fail = min_reached || (prod[PROD_W-1:ACC_W-1] != '0);
      // Magnitude past the signed maximum: only exact 2^63 with '-' survives
      if (!dig_fail && sum[ACC_W-1]) begin
        if ((sum[ACC_W-1:0] == SIGNED_MIN_MAG) && negative) begin
          dig_min = 1'b1;
        end else begin
          dig_fail = 1'b1;
        end
      end
    end else begin
      dig_fail = (prod[PROD_W-1:ACC_W] != '0) || sum[ACC_W];
    end
  end

  // ------------------------------------------------------------------
  // Parse state update
  // ------------------------------------------------------------------
  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    negative_next    = negative;
    active_base_next = active_base;
    min_reached_next = min_reached;
    failed_next      = failed;

    if (s_tuser && !failed) begin
      case (phase)
        PH_LEAD: begin
          if (!is_space) begin
            active_base_next = base_select;
            if (ch == CH_PLUS) begin
              phase_next = PH_NEED;
            end else if (ch == CH_MINUS) begin
              if (!signed_mode) begin
                failed_next = 1'b1;
              end else begin
                negative_next = 1'b1;
                phase_next    = PH_NEED;
              end
            end else if (ch == CH_0) begin
              phase_next = PH_ZERO;
            end else if (dig_fail) begin
              failed_next = 1'b1;
            end else begin
              accumulator_next = sum[ACC_W-1:0];
              min_reached_next = min_reached || dig_min;
              phase_next       = PH_DIGITS;
            end
          end
        end
        PH_ZERO: begin
          if (is_space) begin
            phase_next = PH_TRAIL;
          end else if ((ch == CH_LC_X) || (ch == CH_UC_X)) begin
            // A prefix is only legal with the auto base
            if (active_base != BASE_AUTO) begin
              failed_next = 1'b1;
            end else begin
              active_base_next = BASE_HEX;
              phase_next       = PH_NEED;
            end
          end else if (dig_fail) begin
            failed_next = 1'b1;
          end else begin
            accumulator_next = sum[ACC_W-1:0];
            min_reached_next = min_reached || dig_min;
            phase_next       = PH_DIGITS;
          end
        end
        PH_NEED, PH_DIGITS: begin
          if (is_space) begin
            // A space right after a sign or prefix is an error
            if (phase == PH_NEED) begin
              failed_next = 1'b1;
            end else begin
              phase_next = PH_TRAIL;
            end
          end else if (dig_fail) begin
            failed_next = 1'b1;
          end else begin
            accumulator_next = sum[ACC_W-1:0];
            min_reached_next = min_reached || dig_min;
            phase_next       = PH_DIGITS;
          end
        end
        default: begin
          // Trailing phase: only spaces may follow
          if (!is_space) begin
            failed_next = 1'b1;
          end
        end
      endcase
    end
  end

  // Result as seen after this character
  assign res_ok = !failed_next &&
                  ((phase_next == PH_ZERO) || (phase_next == PH_DIGITS) ||
                   (phase_next == PH_TRAIL));

  always_comb begin
    res_new.ok  = res_ok;
    res_new.neg = res_ok && negative_next;
    res_new.mag = res_ok ? accumulator_next : '0;
  end

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  assign s_tready = !skid_valid;
  assign in_take  = s_tvalid && s_tready;
  assign res_in   = in_take && s_tlast;
  assign out_free = !m_tvalid || m_tready;

  // Advance the parse state on every transaction; clear it after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      accumulator <= '0;
      negative    <= 1'b0;
      active_base <= BASE_AUTO;
      min_reached <= 1'b0;
      failed      <= 1'b0;
    end else if (in_take) begin
      if (s_tlast) begin
        phase       <= PH_LEAD;
        accumulator <= '0;
        negative    <= 1'b0;
        active_base <= BASE_AUTO;
        min_reached <= 1'b0;
        failed      <= 1'b0;
      end else begin
        phase       <= phase_next;
        accumulator <= accumulator_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        min_reached <= min_reached_next;
        failed      <= failed_next;
      end
    end
  end

  // Output valid and skid valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // Skid full means no new result this cycle (s_tready is low)
      m_tvalid   <= skid_valid || res_in;
      skid_valid <= 1'b0;
    end else if (res_in) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload: drain the skid first, park a new result when stalled
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_in) begin
        out_res <= res_new;
      end
    end else if (res_in) begin
      skid_res <= res_new;
    end
  end

  // Apply the sign on the way out
  assign m_tuser = out_res.ok;
  assign m_tdata = out_res.neg ? (ACC_W'(0) - out_res.mag) : out_res.mag;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

import aip_pkg::*;

// One character of a string as it goes onto the input stream
typedef struct packed {
  logic [CHAR_BITS-1:0] code;
  logic                 present;
} char_item_t;

// One parse outcome as the block should report it
typedef struct packed {
  logic             ok;
  logic [ACC_W-1:0] value;
} parse_result_t;

localparam logic [ACC_W-1:0] MAG_MAX_SIGNED   = SIGNED_MIN_MAG - 1;
localparam logic [ACC_W-1:0] MAG_MAX_UNSIGNED = '1;

class parse_scoreboard;
  // register copies
  logic [BASE_W-1:0] base_sel;
  logic              sgn_mode;
  // parse state copies
  logic [2:0]        phase;
  logic [ACC_W-1:0]  acc;
  logic              neg;
  logic [BASE_W-1:0] abase;
  logic              at_min;
  logic              bad;

  parse_result_t     parses_due[$];
  int                errors;

  function new();
    base_sel = BASE_AUTO;
    sgn_mode = 1'b1;
    errors   = 0;
    restart();
  endfunction

  function void restart();
    phase  = PH_LEAD;
    acc    = '0;
    neg    = 1'b0;
    abase  = BASE_AUTO;
    at_min = 1'b0;
    bad    = 1'b0;
  endfunction

  function void configure(logic idx, logic [DATA_W-1:0] data);
    if (idx == REG_BASE_SELECT) begin
      base_sel = data[BASE_W-1:0];
    end else begin
      sgn_mode = data[0];
    end
  endfunction

  // Digit weight of a character, -1 when it is neither 0-9 nor, in hex, a-f or A-F
  function int digit_value(logic [CHAR_BITS-1:0] c, logic [ACC_W-1:0] b);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (b != ACC_W'(BASE_HEX)) return -1;
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  // Multiply-add one digit into the magnitude, with overflow checks
  function void fold_digit(logic [CHAR_BITS-1:0] c);
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] v;
    int               d;
    b = (abase == BASE_AUTO) ? ACC_W'(BASE_DEC) : ACC_W'(abase);
    d = digit_value(c, b);
    if (d < 0) begin
      bad = 1'b1;
      return;
    end
    if (sgn_mode) begin
      if (at_min || acc > MAG_MAX_SIGNED / b) begin
        bad = 1'b1;
        return;
      end
      v = acc * b + ACC_W'(d);
      if (v > MAG_MAX_SIGNED) begin
        // only the most negative value may pass the signed limit
        if (v == SIGNED_MIN_MAG && neg) begin
          at_min = 1'b1;
        end else begin
          bad = 1'b1;
          return;
        end
      end
      acc = v;
    end else begin
      if (acc > MAG_MAX_UNSIGNED / b) begin
        bad = 1'b1;
        return;
      end
      v = acc * b;
      if (v + ACC_W'(d) < v) begin
        bad = 1'b1;
        return;
      end
      acc = v + ACC_W'(d);
    end
    phase = PH_DIGITS;
  endfunction

  function void advance_parse(logic [CHAR_BITS-1:0] c);
    logic sp;
    sp = (c == CH_SPACE);
    case (phase)
      PH_LEAD: begin
        if (sp) return;
        abase = base_sel;
        if (c == CH_PLUS) begin
          phase = PH_NEED;
        end else if (c == CH_MINUS) begin
          if (!sgn_mode) begin
            bad = 1'b1;
            return;
          end
          neg   = 1'b1;
          phase = PH_NEED;
        end else if (c == CH_0) begin
          phase = PH_ZERO;
        end else begin
          fold_digit(c);
        end
      end
      PH_ZERO: begin
        if (sp) begin
          phase = PH_TRAIL;
        end else if (c == CH_LC_X || c == CH_UC_X) begin
          // hex prefix only when the base is still auto
          if (abase != BASE_AUTO) begin
            bad = 1'b1;
          end else begin
            abase = BASE_HEX;
            phase = PH_NEED;
          end
        end else begin
          fold_digit(c);
        end
      end
      PH_NEED: begin
        if (sp) bad = 1'b1;
        else fold_digit(c);
      end
      PH_DIGITS: begin
        if (sp) phase = PH_TRAIL;
        else fold_digit(c);
      end
      default: begin
        if (!sp) bad = 1'b1;
      end
    endcase
  endfunction

  // Note one accepted character; a closing one queues the expected outcome
  function void note_char(logic [CHAR_BITS-1:0] code, logic present, logic last);
    parse_result_t r;
    if (present && !bad) advance_parse(code);
    if (!last) return;
    r.ok    = !bad && (phase == PH_ZERO || phase == PH_DIGITS || phase == PH_TRAIL);
    r.value = !r.ok ? '0 : (neg ? ACC_W'(0) - acc : acc);
    parses_due.push_back(r);
    restart();
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic ok, logic [ACC_W-1:0] value);
    parse_result_t due;
    if (parses_due.size() == 0) begin
      report_mismatch($sformatf("result with none due, ok=%0b value=%h", ok, value));
      return;
    end
    due = parses_due.pop_front();
    if (ok !== due.ok)
      report_mismatch($sformatf("ok flag %0b, want %0b", ok, due.ok));
    if (value !== due.value)
      report_mismatch($sformatf("value %h, want %h", value, due.value));
  endtask
endclass

module testbench;

  // Cycles with no transaction anywhere before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off
  localparam int HOLD_CYCLES = 150;
  // Random input items per configuration phase
  localparam int PHASE_ITEMS = 40;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ADDR_W-1:0]    paddr    = '0;
  logic [DATA_W-1:0]    pwdata   = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata  = '0;   // [15:0] char_code
  logic                 s_tuser  = 1'b0; // [0] char_present
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;         // [63:0] value_bits
  logic                 m_tuser;         // [0] ok

  parse_scoreboard      sb;
  char_item_t           str_q[$];
  int                   items_sent    = 0;
  int                   send_idle_pct = 23;
  int                   recv_idle_pct = 62;
  logic                 hold_start    = 1'b0;
  int                   idle_cycles   = 0;

  // Register settings of the random phases: auto, extremes and odd bases
  logic [BASE_W-1:0] rand_bases [9] = '{BASE_AUTO, 5'd2, 5'd31, BASE_HEX, 5'd1, 5'd8,
                                        BASE_DEC, BASE_AUTO, BASE_HEX};
  logic              rand_signed[9] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                        1'b1, 1'b0, 1'b1};

  ascii_integer_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offer one character at a falling edge, with random gaps in front of it;
  // hold it until the transaction completes, then log it for prediction.
  task automatic send_char(logic [15:0] code, logic present, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tuser  <= present;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_char(code, present, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Send the built string, closing it with tlast; an empty one becomes a
  // single absent character that carries tlast.
  task automatic send_string();
    int n;
    if (str_q.size() == 0) str_q.push_back('{16'h0000, 1'b0});
    n = str_q.size();
    for (int i = 0; i < n; i++) send_char(str_q[i].code, str_q[i].present, i == n - 1);
    str_q.delete();
  endtask

  function automatic void add_text(string s);
    foreach (s[i]) str_q.push_back('{{8'h00, s[i]}, 1'b1});
  endfunction

  function automatic void add_code(logic [15:0] c, logic present);
    str_q.push_back('{c, present});
  endfunction

  task automatic send_text(string s);
    add_text(s);
    send_string();
  endtask

  // Wait out every result still due, then leave the block idle before going on
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.parses_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, then psel drops and the bus idles
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.configure(addr[2], data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [BASE_W-1:0] bsel, logic sgn);
    settle();
    write_reg({REG_BASE_SELECT, 2'b00}, DATA_W'(bsel));
    write_reg({REG_SIGNED_MODE, 2'b00}, DATA_W'(sgn));
  endtask

  function automatic char_item_t noise_char();
    string alpha = " +-0xX9aFgz";
    case ($urandom_range(2))
      0:       return '{16'($urandom), 1'b1};
      1:       return '{{8'h00, alpha[$urandom_range(alpha.len() - 1)]}, 1'b1};
      default: return '{16'($urandom), 1'b0};
    endcase
  endfunction

  // Render a magnitude in base 2..16, mixing the case of hex letters
  function automatic void add_number(logic [ACC_W-1:0] mag, int b);
    logic [ACC_W-1:0] m;
    int               d;
    char_item_t       digs[$];
    logic [15:0]      c;
    m = mag;
    do begin
      d = int'(m % ACC_W'(b));
      if (d < 10) c = CH_0 + 16'(d);
      else c = ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 16'(d - 10);
      digs.push_front('{c, 1'b1});
      m = m / ACC_W'(b);
    end while (m != 0);
    foreach (digs[i]) str_q.push_back(digs[i]);
  endfunction

  // Mostly well-formed numbers with random content; some noise and damage
  function automatic void build_random_string(logic [BASE_W-1:0] bsel);
    int               eff;
    int               pick;
    logic [ACC_W-1:0] mag;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) str_q.push_back(noise_char());
      return;
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_text(" ");
    pick = $urandom_range(99);
    if (pick < 15) add_text("-");
    else if (pick < 30) add_text("+");
    eff = (bsel == BASE_AUTO) ? int'(BASE_DEC) : int'(bsel);
    if (bsel == BASE_AUTO && $urandom_range(3) == 0) begin
      add_text($urandom_range(1) ? "0x" : "0X");
      eff = int'(BASE_HEX);
    end else if ($urandom_range(9) == 0) begin
      add_text("0");
    end
    if (eff >= 2 && eff <= 16) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        mag = ACC_W'($urandom_range(999));
      end else if (pick < 80) begin
        mag = {$urandom, $urandom} >> $urandom_range(63);
      end else begin
        // the signed and unsigned limits and their neighbors
        case ($urandom_range(5))
          0:       mag = MAG_MAX_SIGNED;
          1:       mag = SIGNED_MIN_MAG;
          2:       mag = SIGNED_MIN_MAG + 1;
          3:       mag = MAG_MAX_UNSIGNED;
          4:       mag = MAG_MAX_UNSIGNED / ACC_W'(eff);
          default: mag = '0;
        endcase
      end
      add_number(mag, eff);
    end else begin
      // odd bases only know 0-9, unchecked against the base
      repeat ($urandom_range(3) == 0 ? $urandom_range(10, 22) : $urandom_range(1, 4))
        add_code(CH_0 + 16'($urandom_range(9)), 1'b1);
    end
    // one extra digit pushes limit values over the edge
    if ($urandom_range(9) == 0) add_code(CH_0 + 16'($urandom_range(9)), 1'b1);
    if ($urandom_range(9) == 0)
      str_q.insert($urandom_range(str_q.size() - 1), noise_char());
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_text(" ");
  endfunction

  // Receiver: random backpressure, plus the long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every result transaction against the oldest outcome due
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Watchdog: count cycles in which no transaction of any kind completes
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings under the reset settings: auto base, signed
    send_text("");          // empty string
    send_text("  ");        // spaces only
    send_text("-");         // sign with no digit
    send_text("0x");        // prefix with no digit
    send_text(" 0 ");       // lone zero with spaces around it
    send_text("1 2");       // space between digits
    send_text("+ 5");       // failure, then characters that are ignored
    add_text("7");          // closing item carries no character
    add_code(16'h0000, 1'b0);
    send_string();
    add_code(16'hFFFF, 1'b1);
    send_string();
    add_code(16'h0000, 1'b1);
    send_string();
    send_text("0xF");

    // Explicit hex: prefix fails, most negative value passes
    apply_config(BASE_HEX, 1'b1);
    send_text("0x1");
    send_text("-8000000000000000");
    // Unsigned: minus fails even before a zero
    apply_config(BASE_AUTO, 1'b0);
    send_text("-0");
    // Highest odd base
    apply_config(5'd31, 1'b1);
    send_text("9");

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 3; p++) begin
        apply_config(rand_bases[m * 3 + p], rand_signed[m * 3 + p]);
        // stall the receiver once while short strings keep coming
        if (m == 2 && p == 0) hold_start = 1'b1;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
          build_random_string(rand_bases[m * 3 + p]);
          send_string();
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
